>>> rtl/core/distance_vector_route_update_top_defines.svh
// Assertion macros shared by the route update checker.
`ifndef DISTANCE_VECTOR_ROUTE_UPDATE_TOP_DEFINES_SVH
`define DISTANCE_VECTOR_ROUTE_UPDATE_TOP_DEFINES_SVH

// Clocked assertion, quiet while reset is held.
`define DVRU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define DVRU_ASSERT_NEXT(lbl, pre, post, msg) \
  `DVRU_ASSERT(lbl, pre |=> post, msg)

`endif

>>> rtl/core/dvru_pkg.sv
// Shared constants, types and helpers of the distance-vector route update block.
package dvru_pkg;

  localparam int ROUTER_COUNT   = 8;
  localparam int NEIGHBOR_SLOTS = 8;
  localparam int MAX_LINES      = 8;
  localparam int LINES          = (ROUTER_COUNT < MAX_LINES) ? ROUTER_COUNT : MAX_LINES;

  localparam int ROW_W  = 3;
  localparam int SLOT_W = 3;
  localparam int COST_W = 16;
  localparam int ID_W   = 16;
  localparam int IP_W   = 32;
  localparam int SUM_W  = COST_W + 1;
  localparam int ADDR_W = 2 * ROW_W;
  localparam int DIST_DEPTH = 1 << ADDR_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SELF_INDEX    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INFINITE_COST = CFG_IDX_W'(1);

  localparam logic CMD_SET_NEIGHBOR = 1'b0;
  localparam logic CMD_VECTOR_ENTRY = 1'b1;

  localparam logic [COST_W-1:0] RESET_COST = '1;
  localparam logic [ID_W-1:0]   RESET_HOP  = '1;

  typedef logic [ADDR_W-1:0] dist_addr_t;

  typedef struct packed {
    logic              re;
    dist_addr_t        raddr;
    logic              we;
    dist_addr_t        waddr;
    logic [COST_W-1:0] wdata;
  } dist_req_t;

  function automatic logic row_ok(input logic [ROW_W-1:0] r);
    return {1'b0, r} < (ROW_W+1)'(ROUTER_COUNT);
  endfunction

  function automatic logic slot_ok(input logic [SLOT_W-1:0] s);
    return {1'b0, s} < (SLOT_W+1)'(NEIGHBOR_SLOTS);
  endfunction

endpackage

>>> rtl/core/dvru_channels.sv
// Handshake channel interfaces: vector input, route output, register writes.
interface dvru_in_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [dvru_pkg::SLOT_W-1:0] slot;
  logic                        slot_valid;
  logic [dvru_pkg::ROW_W-1:0]  neighbor_row;
  logic [dvru_pkg::ID_W-1:0]   neighbor_id;
  logic [dvru_pkg::COST_W-1:0] link_cost;
  logic [dvru_pkg::IP_W-1:0]   sender_ip;
  logic [dvru_pkg::ROW_W-1:0]  destination;
  logic [dvru_pkg::COST_W-1:0] advertised_cost;
  logic                        last_entry;

  modport source (output valid, command, slot, slot_valid, neighbor_row, neighbor_id,
                  link_cost, sender_ip, destination, advertised_cost, last_entry,
                  input ready);
  modport sink   (input valid, command, slot, slot_valid, neighbor_row, neighbor_id,
                  link_cost, sender_ip, destination, advertised_cost, last_entry,
                  output ready);
endinterface

interface dvru_out_if;
  logic                        valid;
  logic                        ready;
  logic [dvru_pkg::ROW_W-1:0]  route_destination;
  logic [dvru_pkg::COST_W-1:0] route_cost;
  logic [dvru_pkg::ID_W-1:0]   route_next_hop;
  logic                        last_route;

  modport source (output valid, route_destination, route_cost, route_next_hop, last_route,
                  input ready);
  modport sink   (input valid, route_destination, route_cost, route_next_hop, last_route,
                  output ready);
endinterface

interface dvru_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dvru_pkg::CFG_IDX_W-1:0]  index;
  logic [dvru_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/dvru_dist_mem.sv
// Distance matrix RAM: one write and one registered read port, per-entry reset flags.
module dvru_dist_mem (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dvru_pkg::dist_req_t         req_i,
  output logic [dvru_pkg::COST_W-1:0] rdata_o
);
  import dvru_pkg::*;

  logic [COST_W-1:0]     mem [DIST_DEPTH];
  logic [DIST_DEPTH-1:0] written_q;
  logic [COST_W-1:0]     rdata_q;
  logic [COST_W-1:0]     reset_val;

  // Unwritten entries read as their reset value: zero on the diagonal.
  assign reset_val = (req_i.raddr[ADDR_W-1:ROW_W] == req_i.raddr[ROW_W-1:0]) ? '0 : RESET_COST;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (req_i.we) begin
      written_q[req_i.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= written_q[req_i.raddr] ? mem[req_i.raddr] : reset_val;
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/distance_vector_route_update_top.sv
// Distance-vector route update top: neighbor table, matrix RAM, relax and emit sequencer.
// A set-neighbor or unknown-sender entry finishes in IDLE; a RAM check goes on in ENTRY.
// A closing entry with changes runs a relax: destinations whose own cost is zero are skipped,
// others scan every slot (one RAM read per valid slot) and write back; then each line is emitted.
// Reset: matrix reads infinite cost with zero diagonal via per-entry flags; no clearing pass.
module distance_vector_route_update_top (
  input  logic clk_i,
  input  logic rst_ni,
  dvru_in_if.sink    in_i,
  dvru_out_if.source out_o,
  dvru_cfg_if.sink   cfg_i
);
  import dvru_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_ENTRY   = 4'd1;
  localparam logic [3:0] ST_R_OWN   = 4'd2;
  localparam logic [3:0] ST_R_CHK   = 4'd3;
  localparam logic [3:0] ST_R_SCAN  = 4'd4;
  localparam logic [3:0] ST_R_DRAIN = 4'd5;
  localparam logic [3:0] ST_R_WB    = 4'd6;
  localparam logic [3:0] ST_E_RD    = 4'd7;
  localparam logic [3:0] ST_E_LD    = 4'd8;

  // configuration
  logic [ROW_W-1:0]  self_index_q;
  logic [COST_W-1:0] inf_q;
  logic              self_ok;

  // neighbor table
  logic              nb_valid_q [NEIGHBOR_SLOTS];
  logic [IP_W-1:0]   nb_ip_q    [NEIGHBOR_SLOTS];
  logic [ROW_W-1:0]  nb_row_q   [NEIGHBOR_SLOTS];
  logic [ID_W-1:0]   nb_id_q    [NEIGHBOR_SLOTS];
  logic [COST_W-1:0] nb_cost_q  [NEIGHBOR_SLOTS];
  logic [ID_W-1:0]   nh_q       [ROUTER_COUNT];

  logic [3:0]        state_q, state_d;
  logic              changed_q, changed_d;
  logic [ROW_W-1:0]  d_q, d_d;
  logic [SLOT_W-1:0] s_q, s_d;
  logic              pend_q, pend_d;
  logic [SLOT_W-1:0] pend_slot_q, pend_slot_d;
  logic [COST_W-1:0] cur_own_q, cur_own_d;
  logic [SUM_W-1:0]  best_q, best_d;

  logic [ROW_W-1:0]  ent_row_q, ent_dest_q;
  logic [COST_W-1:0] ent_adv_q;
  logic              ent_last_q;

  logic              out_valid_q;
  logic [ROW_W-1:0]  out_dest_q;
  logic [COST_W-1:0] out_cost_q;
  logic [ID_W-1:0]   out_nh_q;
  logic              out_last_q;

  logic              in_fire, cfg_fire, nb_we, ent_load, nh_we, out_load;
  logic              hit;
  logic [SLOT_W-1:0] hit_slot;
  logic [ROW_W-1:0]  hit_row;
  logic              entry_diff, close_go, close_emit;
  logic [ROW_W-1:0]  proc_row;
  logic [COST_W-1:0] proc_val;
  logic [SUM_W-1:0]  proc_sum;
  logic              proc_better;
  logic              last_dest, last_line, last_slot;

  dist_req_t         mem_req;
  logic [COST_W-1:0] mem_rdata;

  dvru_dist_mem u_dist_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;
  assign self_ok     = row_ok(self_index_q);
  assign nb_we       = in_fire && (in_i.command == CMD_SET_NEIGHBOR) && slot_ok(in_i.slot);

  assign last_dest = (d_q == ROW_W'(ROUTER_COUNT - 1));
  assign last_line = (d_q == ROW_W'(LINES - 1));
  assign last_slot = (s_q == SLOT_W'(NEIGHBOR_SLOTS - 1));

  // Sender lookup: lowest matching valid slot wins.
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int s = NEIGHBOR_SLOTS - 1; s >= 0; s--) begin
      if (nb_valid_q[s] && (nb_ip_q[s] == in_i.sender_ip)) begin
        hit      = 1'b1;
        hit_slot = SLOT_W'(s);
      end
    end
  end
  assign hit_row = nb_row_q[hit_slot];

  // Relax datapath; a neighbor row equal to our own row takes the running own cost.
  assign proc_row    = nb_row_q[pend_slot_q];
  assign proc_val    = (proc_row == self_index_q) ? cur_own_q : mem_rdata;
  assign proc_sum    = SUM_W'(nb_cost_q[pend_slot_q]) + SUM_W'(proc_val);
  assign proc_better = pend_q && (proc_sum < best_q);

  always_comb begin
    state_d     = state_q;
    changed_d   = changed_q;
    d_d         = d_q;
    s_d         = s_q;
    pend_d      = 1'b0;
    pend_slot_d = pend_slot_q;
    cur_own_d   = cur_own_q;
    best_d      = best_q;
    ent_load    = 1'b0;
    nh_we       = 1'b0;
    out_load    = 1'b0;
    entry_diff  = 1'b0;
    close_go    = 1'b0;
    close_emit  = 1'b0;
    mem_req     = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire && (in_i.command == CMD_VECTOR_ENTRY) && hit) begin
          ent_load = 1'b1;
          if (row_ok(hit_row) && row_ok(in_i.destination)) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = {hit_row, in_i.destination};
            state_d       = ST_ENTRY;
          end else if (in_i.last_entry) begin
            close_go   = 1'b1;
            close_emit = changed_q;
          end
        end
      end
      ST_ENTRY: begin
        entry_diff = (mem_rdata != ent_adv_q);
        if (entry_diff) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = {ent_row_q, ent_dest_q};
          mem_req.wdata = ent_adv_q;
        end
        if (ent_last_q) begin
          close_go   = 1'b1;
          close_emit = changed_q || entry_diff;
        end else begin
          changed_d = changed_q || entry_diff;
          state_d   = ST_IDLE;
        end
      end
      ST_R_OWN: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = {self_index_q, d_q};
        state_d       = ST_R_CHK;
      end
      ST_R_CHK: begin
        if (mem_rdata == '0) begin
          // skip destinations we reach at zero cost
          if (last_dest) begin
            d_d     = '0;
            state_d = ST_E_RD;
          end else begin
            d_d     = d_q + ROW_W'(1);
            state_d = ST_R_OWN;
          end
        end else begin
          cur_own_d = mem_rdata;
          best_d    = {1'b0, inf_q};
          s_d       = '0;
          state_d   = ST_R_SCAN;
        end
      end
      ST_R_SCAN: begin
        if (proc_better) begin
          best_d    = proc_sum;
          cur_own_d = proc_sum[COST_W-1:0];
          nh_we     = 1'b1;
        end
        pend_d        = nb_valid_q[s_q] && row_ok(nb_row_q[s_q]);
        pend_slot_d   = s_q;
        mem_req.re    = pend_d;
        mem_req.raddr = {nb_row_q[s_q], d_q};
        if (last_slot) begin
          state_d = ST_R_DRAIN;
        end else begin
          s_d = s_q + SLOT_W'(1);
        end
      end
      ST_R_DRAIN: begin
        if (proc_better) begin
          best_d    = proc_sum;
          cur_own_d = proc_sum[COST_W-1:0];
          nh_we     = 1'b1;
        end
        state_d = ST_R_WB;
      end
      ST_R_WB: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = {self_index_q, d_q};
        mem_req.wdata = cur_own_q;
        if (last_dest) begin
          d_d     = '0;
          state_d = ST_E_RD;
        end else begin
          d_d     = d_q + ROW_W'(1);
          state_d = ST_R_OWN;
        end
      end
      ST_E_RD: begin
        mem_req.re    = self_ok;
        mem_req.raddr = {self_index_q, d_q};
        state_d       = ST_E_LD;
      end
      ST_E_LD: begin
        // hold the read data until the output register frees up
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          if (last_line) begin
            state_d = ST_IDLE;
          end else begin
            d_d     = d_q + ROW_W'(1);
            state_d = ST_E_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (close_go) begin
      changed_d = 1'b0;
      if (close_emit) begin
        d_d     = '0;
        state_d = self_ok ? ST_R_OWN : ST_E_RD;
      end else begin
        state_d = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      changed_q    <= 1'b0;
      d_q          <= '0;
      s_q          <= '0;
      pend_q       <= 1'b0;
      pend_slot_q  <= '0;
      out_valid_q  <= 1'b0;
      self_index_q <= '0;
      inf_q        <= RESET_COST;
      for (int i = 0; i < NEIGHBOR_SLOTS; i++) begin
        nb_valid_q[i] <= 1'b0;
      end
      for (int i = 0; i < ROUTER_COUNT; i++) begin
        nh_q[i] <= RESET_HOP;
      end
    end else begin
      state_q     <= state_d;
      changed_q   <= changed_d;
      d_q         <= d_d;
      s_q         <= s_d;
      pend_q      <= pend_d;
      pend_slot_q <= pend_slot_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_fire) begin
        case (cfg_i.index)
          REG_SELF_INDEX:    self_index_q <= cfg_i.data[ROW_W-1:0];
          REG_INFINITE_COST: inf_q        <= cfg_i.data[COST_W-1:0];
          default: ;
        endcase
      end
      if (nb_we) begin
        nb_valid_q[in_i.slot] <= in_i.slot_valid;
      end
      if (nh_we) begin
        nh_q[d_q] <= nb_id_q[pend_slot_q];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_own_q <= cur_own_d;
    best_q    <= best_d;
    if (nb_we) begin
      nb_ip_q[in_i.slot]   <= in_i.sender_ip;
      nb_row_q[in_i.slot]  <= in_i.neighbor_row;
      nb_id_q[in_i.slot]   <= in_i.neighbor_id;
      nb_cost_q[in_i.slot] <= in_i.link_cost;
    end
    if (ent_load) begin
      ent_row_q  <= hit_row;
      ent_dest_q <= in_i.destination;
      ent_adv_q  <= in_i.advertised_cost;
      ent_last_q <= in_i.last_entry;
    end
    if (out_load) begin
      out_dest_q <= d_q;
      out_cost_q <= self_ok ? mem_rdata : inf_q;
      out_nh_q   <= nh_q[d_q];
      out_last_q <= last_line;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.route_destination = out_dest_q;
  assign out_o.route_cost        = out_cost_q;
  assign out_o.route_next_hop    = out_nh_q;
  assign out_o.last_route        = out_last_q;

endmodule

>>> rtl/core/dvru_checker.sv
// Port-level checker for the route update top, attached by bind.
module dvru_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        command_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [dvru_pkg::ROW_W-1:0]  route_destination_i,
  input logic [dvru_pkg::COST_W-1:0] route_cost_i,
  input logic                        last_route_i
);
  import dvru_pkg::*;
  `include "distance_vector_route_update_top_defines.svh"

  localparam logic [ROW_W-1:0] LAST_DEST = ROW_W'(LINES - 1);

  `DVRU_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(route_destination_i) && $stable(route_cost_i), "route line changed while stalled")
  `DVRU_ASSERT(a_last_line, out_valid_i && last_route_i |-> route_destination_i == LAST_DEST, "last route flag on wrong line")
  `DVRU_ASSERT(a_busy_mid_table, out_valid_i && !last_route_i |-> !in_ready_i, "input taken while table in flight")
  `DVRU_ASSERT_NEXT(a_set_one_cycle, in_valid_i && in_ready_i && command_i == CMD_SET_NEIGHBOR, in_ready_i, "set neighbor did not finish in one cycle")

endmodule

bind distance_vector_route_update_top dvru_checker u_dvru_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_i.valid),
  .in_ready_i          (in_i.ready),
  .command_i           (in_i.command),
  .out_valid_i         (out_o.valid),
  .out_ready_i         (out_o.ready),
  .route_destination_i (out_o.route_destination),
  .route_cost_i        (out_o.route_cost),
  .last_route_i        (out_o.last_route)
);

>>> test/tb_distance_vector_route_update_top.sv
// Self-checking testbench of the distance-vector route update block.
`timescale 1ns / 100ps

module tb_distance_vector_route_update_top;
  import dvru_pkg::*;

  localparam int PHASES        = 5;
  localparam int PHASE_ITEMS   = 16;
  localparam int POOL_SIZE     = 4;
  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic              command;
    logic [SLOT_W-1:0] slot;
    logic              slot_valid;
    logic [ROW_W-1:0]  neighbor_row;
    logic [ID_W-1:0]   neighbor_id;
    logic [COST_W-1:0] link_cost;
    logic [IP_W-1:0]   sender_ip;
    logic [ROW_W-1:0]  destination;
    logic [COST_W-1:0] advertised_cost;
    logic              last_entry;
  } route_cmd_t;

  typedef struct packed {
    logic [ROW_W-1:0]  route_destination;
    logic [COST_W-1:0] route_cost;
    logic [ID_W-1:0]   route_next_hop;
    logic              last_route;
  } route_line_t;

  // Directed row; cost and hop lists run from destination LINES-1 down to 0.
  typedef struct packed {
    route_cmd_t                    cmd;
    logic                          fixed;
    logic [3:0]                    n_lines;
    logic [LINES-1:0][COST_W-1:0]  cost;
    logic [LINES-1:0][ID_W-1:0]    hop;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  dvru_in_if  in_if ();
  dvru_out_if out_if ();
  dvru_cfg_if cfg_if ();

  distance_vector_route_update_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #10 clk_i = ~clk_i;

  // Predicted block state
  logic [COST_W-1:0] dist_mx [ROUTER_COUNT][ROUTER_COUNT];
  logic [ID_W-1:0]   pred_hop [ROUTER_COUNT];
  logic              nb_valid [NEIGHBOR_SLOTS];
  logic [IP_W-1:0]   nb_addr [NEIGHBOR_SLOTS];
  logic [ROW_W-1:0]  nb_row [NEIGHBOR_SLOTS];
  logic [ID_W-1:0]   nb_id [NEIGHBOR_SLOTS];
  logic [COST_W-1:0] nb_link [NEIGHBOR_SLOTS];
  logic              vec_changed;
  logic [ROW_W-1:0]  self_idx;
  logic [COST_W-1:0] inf_cost;

  route_line_t pred_line [LINES];
  route_line_t pending_routes [$];
  stim_row_t   directed_tab [$];
  logic [IP_W-1:0] ip_pool [POOL_SIZE];

  logic hold_req = 1'b0;
  logic no_idle = 1'b0;
  int   hold_left = 0;
  bit   hold_seen = 1'b0;

  int cycle_cnt = 0;
  int items_sent = 0;
  int lines_checked = 0;
  int mismatch_cnt = 0;
  int settings_cnt = 1;

  logic [ROW_W-1:0]  phase_self [PHASES] = '{3'd3, 3'd7, 3'd0, 3'd5, 3'd1};
  logic [COST_W-1:0] phase_inf [PHASES]  = '{16'd1000, 16'd0, 16'hFFFF, 16'd0, 16'd40};

  // Update the predicted state for one transaction; return the number of route lines.
  function automatic int relax_predict(input route_cmd_t c);
    int hit;
    logic [ROW_W-1:0] row;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] best;
    bit emit;
    hit = -1;
    if (c.command == CMD_SET_NEIGHBOR) begin
      nb_valid[c.slot] = c.slot_valid;
      nb_addr[c.slot]  = c.sender_ip;
      nb_row[c.slot]   = c.neighbor_row;
      nb_id[c.slot]    = c.neighbor_id;
      nb_link[c.slot]  = c.link_cost;
      return 0;
    end
    // Lowest matching slot wins
    for (int s = 0; s < NEIGHBOR_SLOTS; s++) begin
      if (hit < 0 && nb_valid[s] && nb_addr[s] == c.sender_ip) hit = s;
    end
    if (hit < 0) return 0;
    row = nb_row[hit];
    if (dist_mx[row][c.destination] != c.advertised_cost) begin
      dist_mx[row][c.destination] = c.advertised_cost;
      vec_changed = 1'b1;
    end
    if (!c.last_entry) return 0;
    emit = vec_changed;
    vec_changed = 1'b0;
    if (!emit) return 0;
    for (int d = 0; d < ROUTER_COUNT; d++) begin
      if (dist_mx[self_idx][d] == '0) continue;
      best = SUM_W'(inf_cost);
      for (int s = 0; s < NEIGHBOR_SLOTS; s++) begin
        if (!nb_valid[s]) continue;
        sum = SUM_W'(nb_link[s]) + SUM_W'(dist_mx[nb_row[s]][d]);
        if (sum < best) begin
          best = sum;
          dist_mx[self_idx][d] = sum[COST_W-1:0];
          pred_hop[d] = nb_id[s];
        end
      end
    end
    for (int d = 0; d < LINES; d++) begin
      pred_line[d].route_destination = ROW_W'(d);
      pred_line[d].route_cost        = dist_mx[self_idx][d];
      pred_line[d].route_next_hop    = pred_hop[d];
      pred_line[d].last_route        = (d == LINES - 1);
    end
    return LINES;
  endfunction

  function automatic route_cmd_t nb_cmd(input logic [SLOT_W-1:0] slot, input logic vld,
                                        input logic [ROW_W-1:0] row, input logic [ID_W-1:0] id,
                                        input logic [COST_W-1:0] cost, input logic [IP_W-1:0] ip);
    route_cmd_t c;
    c = '0;
    c.command      = CMD_SET_NEIGHBOR;
    c.slot         = slot;
    c.slot_valid   = vld;
    c.neighbor_row = row;
    c.neighbor_id  = id;
    c.link_cost    = cost;
    c.sender_ip    = ip;
    return c;
  endfunction

  function automatic route_cmd_t entry_cmd(input logic [IP_W-1:0] ip,
                                           input logic [ROW_W-1:0] dst,
                                           input logic [COST_W-1:0] cost, input logic last);
    route_cmd_t c;
    c = '0;
    c.command         = CMD_VECTOR_ENTRY;
    c.sender_ip       = ip;
    c.destination     = dst;
    c.advertised_cost = cost;
    c.last_entry      = last;
    return c;
  endfunction

  function automatic stim_row_t plain_row(input route_cmd_t c);
    stim_row_t r;
    r = '0;
    r.cmd = c;
    return r;
  endfunction

  function automatic stim_row_t fixed_row(input route_cmd_t c, input int n,
                                          input logic [LINES-1:0][COST_W-1:0] cost,
                                          input logic [LINES-1:0][ID_W-1:0] hop);
    stim_row_t r;
    r.cmd     = c;
    r.fixed   = 1'b1;
    r.n_lines = 4'(n);
    r.cost    = cost;
    r.hop     = hop;
    return r;
  endfunction

  // Random command with every field filled, used as the base of all random items.
  function automatic route_cmd_t rand_cmd();
    logic [95:0] raw;
    raw = {$urandom(), $urandom(), $urandom()};
    return raw[$bits(route_cmd_t)-1:0];
  endfunction

  function automatic logic [COST_W-1:0] rand_cost(input int small_max);
    int pick;
    pick = $urandom_range(99);
    if (pick < 65) return COST_W'($urandom_range(0, small_max));
    if (pick < 78) return '1;
    if (pick < 85) return '0;
    return COST_W'($urandom());
  endfunction

  function automatic route_cmd_t rand_neighbor();
    route_cmd_t c;
    c = rand_cmd();
    c.command    = CMD_SET_NEIGHBOR;
    c.slot_valid = ($urandom_range(99) < 90);
    c.link_cost  = rand_cost(20);
    c.sender_ip  = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
    return c;
  endfunction

  function automatic route_cmd_t rand_entry(input logic [IP_W-1:0] ip, input logic last);
    route_cmd_t c;
    c = rand_cmd();
    c.command         = CMD_VECTOR_ENTRY;
    c.sender_ip       = ip;
    c.advertised_cost = rand_cost(30);
    c.last_entry      = last;
    return c;
  endfunction

  // Offer one transaction, wait for acceptance, then queue its route lines.
  task automatic send_row(input stim_row_t row);
    int n;
    while (!no_idle && $urandom_range(99) < 19) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid           <= 1'b1;
    in_if.command         <= row.cmd.command;
    in_if.slot            <= row.cmd.slot;
    in_if.slot_valid      <= row.cmd.slot_valid;
    in_if.neighbor_row    <= row.cmd.neighbor_row;
    in_if.neighbor_id     <= row.cmd.neighbor_id;
    in_if.link_cost       <= row.cmd.link_cost;
    in_if.sender_ip       <= row.cmd.sender_ip;
    in_if.destination     <= row.cmd.destination;
    in_if.advertised_cost <= row.cmd.advertised_cost;
    in_if.last_entry      <= row.cmd.last_entry;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    items_sent++;
    n = relax_predict(row.cmd);
    if (row.fixed) begin
      for (int d = 0; d < int'(row.n_lines); d++) begin
        pending_routes.push_back({ROW_W'(d), row.cost[d], row.hop[d],
                                  1'(d == int'(row.n_lines) - 1)});
      end
    end else begin
      for (int d = 0; d < n; d++) pending_routes.push_back(pred_line[d]);
    end
  endtask

  // Drop valid, wait for every pending line, then let the block go idle.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending_routes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_config(input logic [ROW_W-1:0] self_val, input logic [COST_W-1:0] inf_val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= REG_SELF_INDEX;
    cfg_if.data  <= CFG_DATA_W'(self_val);
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.index <= REG_INFINITE_COST;
    cfg_if.data  <= inf_val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    self_idx = self_val;
    inf_cost = inf_val;
    settings_cnt++;
  endtask

  // Route output sink: random back-pressure plus one long hold-off.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (hold_req && !hold_seen) begin
        hold_seen <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= no_idle || ($urandom_range(99) >= 19);
      end
    end
  end

  always @(posedge clk_i) begin
    route_line_t got;
    route_line_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = {out_if.route_destination, out_if.route_cost, out_if.route_next_hop,
             out_if.last_route};
      if (pending_routes.size() == 0) begin
        if (mismatch_cnt < MAX_REPORTS)
          $display("unexpected route line: dst %0d cost %h hop %h last %b",
                   got.route_destination, got.route_cost, got.route_next_hop, got.last_route);
        mismatch_cnt++;
      end else begin
        want = pending_routes.pop_front();
        lines_checked++;
        if (got.route_destination !== want.route_destination ||
            got.route_cost !== want.route_cost ||
            got.route_next_hop !== want.route_next_hop ||
            got.last_route !== want.last_route) begin
          if (mismatch_cnt < MAX_REPORTS)
            $display("route mismatch: exp dst %0d cost %h hop %h last %b, got dst %0d cost %h hop %h last %b",
                     want.route_destination, want.route_cost, want.route_next_hop,
                     want.last_route, got.route_destination, got.route_cost,
                     got.route_next_hop, got.last_route);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d route lines pending", cycle_cnt,
             pending_routes.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int cnt;
    int len;
    int sel;
    bit broken;
    logic [COST_W-1:0] inf_val;

    in_if.valid           = 1'b0;
    in_if.command         = CMD_SET_NEIGHBOR;
    in_if.slot            = '0;
    in_if.slot_valid      = 1'b0;
    in_if.neighbor_row    = '0;
    in_if.neighbor_id     = '0;
    in_if.link_cost       = '0;
    in_if.sender_ip       = '0;
    in_if.destination     = '0;
    in_if.advertised_cost = '0;
    in_if.last_entry      = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = REG_SELF_INDEX;
    cfg_if.data           = '0;

    for (int r = 0; r < ROUTER_COUNT; r++) begin
      for (int c = 0; c < ROUTER_COUNT; c++) dist_mx[r][c] = (r == c) ? '0 : RESET_COST;
      pred_hop[r] = RESET_HOP;
    end
    for (int s = 0; s < NEIGHBOR_SLOTS; s++) begin
      nb_valid[s] = 1'b0;
      nb_addr[s]  = '0;
      nb_row[s]   = '0;
      nb_id[s]    = '0;
      nb_link[s]  = '0;
    end
    vec_changed = 1'b0;
    self_idx    = '0;
    inf_cost    = RESET_COST;

    // Unknown sender right after reset
    directed_tab.push_back(fixed_row(entry_cmd(32'h0A000001, 3'd1, 16'd4, 1'b1), 0, '0, '0));
    directed_tab.push_back(fixed_row(nb_cmd(3'd0, 1'b1, 3'd1, 16'h0101, 16'd5, 32'h0A000001),
                                     0, '0, '0));
    directed_tab.push_back(fixed_row(entry_cmd(32'h0A000001, 3'd2, 16'd3, 1'b0), 0, '0, '0));
    directed_tab.push_back(fixed_row(entry_cmd(32'h0A000001, 3'd1, 16'd0, 1'b1), 8,
      {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd8, 16'd5, 16'd0},
      {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0101, 16'h0101, 16'hFFFF}));
    // Closing entry that changes nothing emits no table
    directed_tab.push_back(fixed_row(entry_cmd(32'h0A000001, 3'd2, 16'd3, 1'b1), 0, '0, '0));
    directed_tab.push_back(fixed_row(nb_cmd(3'd7, 1'b1, 3'd7, 16'hFFFF, 16'd0, 32'hFFFFFFFF),
                                     0, '0, '0));
    directed_tab.push_back(fixed_row(entry_cmd(32'hFFFFFFFF, 3'd3, 16'd0, 1'b1), 8,
      {16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd8, 16'd5, 16'd0},
      {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0101, 16'h0101, 16'hFFFF}));
    // Own cost already zero: destination is left alone
    directed_tab.push_back(plain_row(entry_cmd(32'hFFFFFFFF, 3'd3, 16'hFFFF, 1'b1)));
    // Sum above 16 bits must not wrap into a small cost
    directed_tab.push_back(plain_row(nb_cmd(3'd3, 1'b1, 3'd2, 16'h1234, 16'hFFFF,
                                            32'h12345678)));
    directed_tab.push_back(plain_row(entry_cmd(32'h12345678, 3'd4, 16'hFFFE, 1'b1)));
    // Duplicate address and equal sums: lower slot wins
    directed_tab.push_back(plain_row(nb_cmd(3'd1, 1'b1, 3'd1, 16'h2222, 16'd5, 32'h0A000001)));
    directed_tab.push_back(plain_row(entry_cmd(32'h0A000001, 3'd5, 16'd1, 1'b1)));
    directed_tab.push_back(plain_row(nb_cmd(3'd0, 1'b0, 3'd1, 16'h0101, 16'd5, 32'h0A000001)));
    directed_tab.push_back(plain_row(entry_cmd(32'h0A000001, 3'd6, 16'd2, 1'b1)));
    // Neighbor mapped onto the own row
    directed_tab.push_back(plain_row(nb_cmd(3'd2, 1'b1, 3'd0, 16'h0000, 16'd1, 32'h00000000)));
    directed_tab.push_back(plain_row(entry_cmd(32'h00000000, 3'd7, 16'd0, 1'b0)));
    // Unknown sender closing mark inside an open vector is ignored
    directed_tab.push_back(fixed_row(entry_cmd(32'hDEADBEEF, 3'd7, 16'd9, 1'b1), 0, '0, '0));
    directed_tab.push_back(plain_row(entry_cmd(32'h00000000, 3'd0, 16'd5, 1'b1)));
    directed_tab.push_back(plain_row(nb_cmd(3'd3, 1'b0, 3'd2, 16'h1234, 16'hFFFF,
                                            32'h12345678)));
    directed_tab.push_back(fixed_row(entry_cmd(32'h12345678, 3'd4, 16'd1, 1'b1), 0, '0, '0));
    directed_tab.push_back(plain_row(entry_cmd(32'hFFFFFFFF, 3'd7, 16'hFFFF, 1'b0)));
    directed_tab.push_back(plain_row(entry_cmd(32'hFFFFFFFF, 3'd7, 16'hFFFF, 1'b1)));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_tab[i]) send_row(directed_tab[i]);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      inf_val = (p == 3) ? COST_W'($urandom()) : phase_inf[p];
      load_config(phase_self[p], inf_val);
      if (p == 0) hold_req <= 1'b1;
      if (p == 2) no_idle <= 1'b1;
      if (p == 3) no_idle <= 1'b0;
      for (int k = 0; k < POOL_SIZE; k++) ip_pool[k] = $urandom();
      for (int k = 0; k < POOL_SIZE; k++) send_row(plain_row(rand_neighbor()));
      cnt = POOL_SIZE;
      while (cnt < PHASE_ITEMS) begin
        sel = $urandom_range(99);
        if (sel < 10) begin
          send_row(plain_row(rand_neighbor()));
          cnt++;
        end else if (sel < 18) begin
          // Sender from outside the pool, ignored by the block
          send_row(plain_row(rand_entry($urandom(), 1'($urandom_range(0, 1)))));
        end else begin
          len = $urandom_range(1, 4);
          broken = ($urandom_range(99) < 10);
          sel = $urandom_range(0, POOL_SIZE - 1);
          for (int e = 0; e < len; e++)
            send_row(plain_row(rand_entry(ip_pool[sel], 1'(e == len - 1 && !broken))));
          cnt += len;
        end
      end
      settle();
    end

    $display("Sent %0d input transactions over %0d register settings, with one %0d-cycle output stall.",
             items_sent, settings_cnt, HOLD_CYCLES);
    $display("Checked %0d route lines, %0d mismatches, %0d still pending.",
             lines_checked, mismatch_cnt, pending_routes.size());
    if (mismatch_cnt == 0 && pending_routes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
